[rtl/assert_macros.svh]
// Assertion macros used by the top level of the 3x3 box smoother
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("invariant violated");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication violated");

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

[rtl/ibs_pkg.sv]
// Package: shared types, constants and the reciprocal table of the box smoother
`timescale 1ns / 1ps
package ibs_pkg;

	localparam int PIX_W      = 8;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 4096;
	localparam int LINE_DEPTH = MAX_WIDTH;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int WIDTH_W    = LINE_AW + 1;
	localparam int HEIGHT_W   = $clog2(MAX_HEIGHT) + 1;
	localparam int COL_W      = LINE_AW;
	localparam int ROW_W      = HEIGHT_W - 1;
	localparam int SUM_W      = PIX_W + 4;
	localparam int CNT_W      = 4;
	localparam int RECIP_SH   = 15;
	localparam int RECIP_W    = RECIP_SH + 1;
	localparam int PROD_W     = SUM_W + RECIP_W;

	typedef logic [PIX_W-1:0] pix_t;
	// window[row][col]; row 0 is the oldest line, col 0 the oldest column
	typedef pix_t [2:0][2:0] win_t;

	// Register indexes of the configuration port
	typedef enum logic {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	// Neighbourhood flags of one result, handed from control to the mean unit
	typedef struct packed {
		logic row_up;    // row above lies inside the frame
		logic row_dn;    // row below lies inside the frame
		logic col_lt;    // column to the left lies inside the frame
		logic col_rt;    // column to the right lies inside the frame
		logic last;      // final result of the frame
	} nbr_flags_t;

	// ceil(2^15 / n): exact floor division for every sum this block can form
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] m;
		unique case (cnt)
			4'd1:    m = 16'd32768;
			4'd2:    m = 16'd16384;
			4'd3:    m = 16'd10923;
			4'd4:    m = 16'd8192;
			4'd6:    m = 16'd5462;
			4'd9:    m = 16'd3641;
			default: m = 16'd32768;
		endcase
		return m;
	endfunction

endpackage

[rtl/image_box_smoother_3x3.sv]
// Top level: 3x3 box smoother with line delay chains, window, control and APB registers
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  s_      | in        | s_tvalid / s_tready  | s_tdata: pixel; s_tuser: cmd
//  m_      | out       | m_tvalid / m_tready  | m_tdata: smoothed; m_tlast: frame_last
//  apb     | in        | psel/penable/pready  | paddr, pwdata, prdata
//
// One item per cycle while the output is not stalled; a result passes, after the accepted item
// that completes it, through state update, masked sum and reciprocal multiply into the output.
// Line stores are two chains of 256 cells, each shifting once per item that does work.
// Reset clears counters and pipeline valids; line and window contents are not cleared.
// A stalled output holds the whole pipeline and s_tready drops in the same cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module image_box_smoother_3x3
	import ibs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // [7:0] pixel
	input  logic        s_tuser,    // [0] cmd: 0 pixel, 1 drain
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [7:0] smoothed
	output logic        m_tlast
);

	logic [WIDTH_W-1:0]    width_q;
	logic [HEIGHT_W-1:0]   height_q;
	logic [COL_W-1:0]      in_col_q;
	logic [ROW_W-1:0]      in_row_q;
	logic                  draining_q;
	logic [WIDTH_W-1:0]    pend_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	win_t                  win_q;
	logic                  v_s1;
	nbr_flags_t            flags_s1;

	reg_idx_t              reg_idx;
	logic                  cfg_wr;
	logic [WIDTH_W-1:0]    wr_width;
	logic [HEIGHT_W-1:0]   wr_height;

	logic                  adv;
	logic                  take;
	logic                  emit;
	logic                  res_last;
	logic                  col_last;
	logic                  row_last;
	logic                  in_col_wrap;
	logic                  in_row_end;
	pix_t                  px;
	pix_t                  newer_tail;
	pix_t                  older_tail;
	logic [WIDTH_W-1:0]    tap_w;
	logic [LINE_AW-1:0]    tap;
	logic [LINE_DEPTH-1:0] ins_sel;
	nbr_flags_t            flags;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Clamp written values to the supported frame size
	always_comb begin
		wr_width  = pwdata[WIDTH_W-1:0];
		wr_height = pwdata[HEIGHT_W-1:0];
		if (wr_width == '0) begin
			wr_width = WIDTH_W'(1);
		end else if (wr_width > WIDTH_W'(MAX_WIDTH)) begin
			wr_width = WIDTH_W'(MAX_WIDTH);
		end
		if (wr_height == '0) begin
			wr_height = HEIGHT_W'(1);
		end else if (wr_height > HEIGHT_W'(MAX_HEIGHT)) begin
			wr_height = HEIGHT_W'(MAX_HEIGHT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(1);
			height_q <= HEIGHT_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  width_q  <= wr_width;
				REG_FRAME_HEIGHT: height_q <= wr_height;
				default:          width_q  <= width_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = 32'(width_q);
			REG_FRAME_HEIGHT: prdata = 32'(height_q);
			default:          prdata = '0;
		endcase
	end

	// Handshake: only items matching the drain phase do any work
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign take     = s_tvalid && adv && (s_tuser == draining_q);
	assign px       = s_tuser ? '0 : s_tdata;

	// Position tests
	assign in_col_wrap = ({1'b0, in_col_q} + WIDTH_W'(1)) >= width_q;
	assign in_row_end  = ({1'b0, in_row_q} + HEIGHT_W'(1)) >= height_q;
	assign col_last    = ({1'b0, col_q} + WIDTH_W'(1)) >= width_q;
	assign row_last    = ({1'b0, row_q} + HEIGHT_W'(1)) >= height_q;
	assign res_last    = row_last && col_last;
	assign emit        = pend_q == (width_q + WIDTH_W'(1));

	// Frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			draining_q <= 1'b0;
			pend_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_wr) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			draining_q <= 1'b0;
			pend_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (take) begin
			if (emit && res_last) begin
				// frame complete: start the next one
				in_col_q   <= '0;
				in_row_q   <= '0;
				draining_q <= 1'b0;
				pend_q     <= '0;
				col_q      <= '0;
				row_q      <= '0;
			end else begin
				in_col_q <= in_col_wrap ? '0 : in_col_q + COL_W'(1);
				if (in_col_wrap && !draining_q) begin
					if (in_row_end) begin
						draining_q <= 1'b1;
					end else begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end
				if (!emit) begin
					pend_q <= pend_q + WIDTH_W'(1);
				end else if (col_last) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// Insert point of the line chains: frame_width cells up to and including the tail
	assign tap_w = WIDTH_W'(LINE_DEPTH) - width_q;
	assign tap   = tap_w[LINE_AW-1:0];

	always_comb begin
		for (int i = 0; i < LINE_DEPTH; i++) begin
			ins_sel[i] = tap == LINE_AW'(i);
		end
	end

	ibs_line u_newer (
		.clk     (clk),
		.en      (take),
		.ins_sel (ins_sel),
		.din     (px),
		.tail    (newer_tail)
	);

	ibs_line u_older (
		.clk     (clk),
		.en      (take),
		.ins_sel (ins_sel),
		.din     (newer_tail),
		.tail    (older_tail)
	);

	// 3x3 window shifts left, new column from the two lines and the pixel
	always_ff @(posedge clk) begin
		if (take) begin
			for (int rr = 0; rr < 3; rr++) begin
				win_q[rr][0] <= win_q[rr][1];
				win_q[rr][1] <= win_q[rr][2];
			end
			win_q[0][2] <= older_tail;
			win_q[1][2] <= newer_tail;
			win_q[2][2] <= px;
		end
	end

	// Stage 1: result position flags
	always_comb begin
		flags.row_up = row_q != '0;
		flags.row_dn = !row_last;
		flags.col_lt = col_q != '0;
		flags.col_rt = !col_last;
		flags.last   = res_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_s1 <= flags;
		end
	end

	ibs_mean u_mean (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s1       (v_s1),
		.flags_s1   (flags_s1),
		.win        (win_q),
		.res_valid  (m_tvalid),
		.smoothed   (m_tdata),
		.frame_last (m_tlast)
	);

	// Checks
	`ASSERT_ALWAYS(a_pend_bound, clk, arst_n, pend_q <= (width_q + WIDTH_W'(1)))
	`ASSERT_ALWAYS(a_in_col_bound, clk, arst_n, ({1'b0, in_col_q} < width_q))
	`ASSERT_IMPLIES(a_last_alone, clk, arst_n, m_tvalid && m_tlast, !v_s1)
	`ASSERT_NEXT(a_frame_restart, clk, arst_n, take && emit && res_last && !cfg_wr, pend_q == '0)

endmodule

[rtl/ibs_cell.sv]
// One storage cell of a line delay chain: shifts from its neighbour or takes the insert
`timescale 1ns / 1ps
module ibs_cell
	import ibs_pkg::*;
(
	input  logic clk,
	input  logic en,      // chain shifts this cycle
	input  logic ins,     // this cell is the insert point for the current width
	input  pix_t din,     // new pixel entering the chain
	input  pix_t prev,    // neighbour towards the chain head
	output pix_t q
);

	pix_t q_q;

	always_ff @(posedge clk) begin
		if (en) begin
			q_q <= ins ? din : prev;
		end
	end

	assign q = q_q;

endmodule

[rtl/ibs_line.sv]
// Line store as a chain of cells: delay of frame_width shifts, fixed tail tap
`timescale 1ns / 1ps
module ibs_line
	import ibs_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [LINE_DEPTH-1:0] ins_sel,   // one-hot insert point
	input  pix_t                  din,
	output pix_t                  tail       // pixel written frame_width shifts ago
);

	pix_t cell_q [LINE_DEPTH];

	// Cells hand data towards the tail; the head cell sees the new pixel as neighbour
	for (genvar i = 0; i < LINE_DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			ibs_cell u_cell (
				.clk  (clk),
				.en   (en),
				.ins  (ins_sel[i]),
				.din  (din),
				.prev (din),
				.q    (cell_q[i])
			);
		end else begin : g_body
			ibs_cell u_cell (
				.clk  (clk),
				.en   (en),
				.ins  (ins_sel[i]),
				.din  (din),
				.prev (cell_q[i-1]),
				.q    (cell_q[i])
			);
		end
	end

	assign tail = cell_q[LINE_DEPTH-1];

endmodule

[rtl/ibs_mean.sv]
// Masked 3x3 sum, reciprocal multiply and output register of the box smoother
`timescale 1ns / 1ps
module ibs_mean
	import ibs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,        // pipeline advances (output free or being taken)
	input  logic       v_s1,
	input  nbr_flags_t flags_s1,
	input  win_t       win,        // window as left by the accepted item
	output logic       res_valid,
	output pix_t       smoothed,
	output logic       frame_last
);

	logic [2:0]         row_en;
	logic [2:0]         col_en;
	logic [1:0]         n_rows;
	logic [1:0]         n_cols;
	logic [CNT_W-1:0]   cnt;
	logic [SUM_W-1:0]   sum;
	logic [PROD_W-1:0]  prod;

	logic               v_s2;
	logic               last_s2;
	logic [SUM_W-1:0]   sum_s2;
	logic [RECIP_W-1:0] m_s2;
	logic               res_valid_q;
	pix_t               res_q;
	logic               last_q;

	// In-frame neighbourhood and its size
	always_comb begin
		row_en = {flags_s1.row_dn, 1'b1, flags_s1.row_up};
		col_en = {flags_s1.col_rt, 1'b1, flags_s1.col_lt};
		n_rows = 2'd1 + 2'(flags_s1.row_up) + 2'(flags_s1.row_dn);
		n_cols = 2'd1 + 2'(flags_s1.col_lt) + 2'(flags_s1.col_rt);
		cnt    = CNT_W'(n_rows) * CNT_W'(n_cols);
	end

	// Masked sum over the nine window cells
	always_comb begin
		sum = '0;
		for (int rr = 0; rr < 3; rr++) begin
			for (int cc = 0; cc < 3; cc++) begin
				if (row_en[rr] && col_en[cc]) begin
					sum = sum + SUM_W'(win[rr][cc]);
				end
			end
		end
	end

	// Stage 2: sum and reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s2  <= sum;
			m_s2    <= recip(cnt);
			last_s2 <= flags_s1.last;
		end
	end

	// Floor division by multiplying with the scaled reciprocal
	assign prod = PROD_W'(sum_s2) * PROD_W'(m_s2);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q  <= prod[RECIP_SH +: PIX_W];
			last_q <= last_s2;
		end
	end

	assign res_valid  = res_valid_q;
	assign smoothed   = res_q;
	assign frame_last = last_q;

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the 3x3 box smoother: raster frames in, smoothed pixels checked
`timescale 1ns / 1ps
module tb_top
	import ibs_pkg::*;
;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;
	localparam int   SETTLE_CYCLES = 8;     // lets the result pipeline empty after its last item
	localparam int   ITEM_BUDGET = 1250;    // frame items over the whole run
	localparam int   HOLD_CYCLES = 400;
	localparam int   HOLD_AFTER = 300;      // results seen before the long receiver hold
	localparam int   CALM_FROM = 1500;      // cycle window with no idling on either side
	localparam int   CALM_TO = 2500;

	typedef struct packed {
		logic cmd;
		pix_t pixel;
	} raster_item_t;

	typedef struct packed {
		pix_t smoothed;
		logic frame_last;
	} smooth_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // [7:0] pixel
	logic        s_tuser = 1'b0;   // [0] cmd: 0 pixel, 1 drain
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] smoothed
	logic        m_tlast;

	image_box_smoother_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Stimulus and expectation stores
	raster_item_t   raster_q[$];
	smooth_result_t smoothed_q[$];
	int             errors = 0;
	int             results_seen = 0;
	int             cycle_count = 0;
	int             useful_items = 0;
	logic           calm;

	assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

	// Predictor state: configuration, line stores, window and raster counters
	logic [8:0]  width_p = 9'd1;
	logic [12:0] height_p = 13'd1;
	pix_t        line_older_p[MAX_WIDTH];
	pix_t        line_newer_p[MAX_WIDTH];
	win_t        win_p = '0;
	int unsigned col_p = 0;
	int unsigned row_p = 0;
	int unsigned pending_p = 0;
	logic        draining_p = 1'b0;
	int unsigned in_col_p = 0;
	int unsigned in_row_p = 0;

	// Abandon the frame in progress; line stores are kept
	function automatic void restart_frame();
		win_p = '0;
		col_p = 0;
		row_p = 0;
		pending_p = 0;
		draining_p = 1'b0;
		in_col_p = 0;
		in_row_p = 0;
	endfunction

	// Register write as seen by the block: masked to the field, then clamped
	function automatic void set_frame_size(input reg_idx_t idx, input logic [31:0] val);
		int unsigned v;
		if (idx == REG_FRAME_WIDTH) begin
			v = val & 32'h1FF;
			if (v < 1) v = 1;
			if (v > MAX_WIDTH) v = MAX_WIDTH;
			width_p = v[8:0];
		end else begin
			v = val & 32'h1FFF;
			if (v < 1) v = 1;
			if (v > MAX_HEIGHT) v = MAX_HEIGHT;
			height_p = v[12:0];
		end
		restart_frame();
	endfunction

	// Advance the window by one accepted item and queue the smoothed pixel it completes
	function automatic void smooth_step(input raster_item_t it);
		logic        is_drain;
		pix_t        px;
		int unsigned ic, r_lo, r_hi, c_lo, c_hi, sum, cnt, rr, cc;
		logic        last;
		is_drain = (it.cmd == CMD_DRAIN);
		// pixels while draining and drains outside draining are dropped
		if (is_drain != draining_p)
			return;
		px = is_drain ? pix_t'(0) : it.pixel;
		ic = in_col_p % MAX_WIDTH;
		for (rr = 0; rr < 3; rr++) begin
			win_p[rr][0] = win_p[rr][1];
			win_p[rr][1] = win_p[rr][2];
		end
		win_p[0][2] = line_older_p[ic];
		win_p[1][2] = line_newer_p[ic];
		win_p[2][2] = px;
		line_older_p[ic] = line_newer_p[ic];
		line_newer_p[ic] = px;

		in_col_p++;
		if (in_col_p >= width_p) begin
			in_col_p = 0;
			if (!draining_p) begin
				in_row_p++;
				if (in_row_p >= height_p)
					draining_p = 1'b1;
			end
		end

		// output lags the input by one row plus one pixel
		if (pending_p < width_p + 1) begin
			pending_p++;
			return;
		end

		r_lo = (row_p > 0) ? 0 : 1;
		r_hi = (row_p + 1 < height_p) ? 2 : 1;
		c_lo = (col_p > 0) ? 0 : 1;
		c_hi = (col_p + 1 < width_p) ? 2 : 1;
		sum = 0;
		cnt = 0;
		for (rr = r_lo; rr <= r_hi; rr++)
			for (cc = c_lo; cc <= c_hi; cc++) begin
				sum += win_p[rr][cc];
				cnt++;
			end
		last = (row_p + 1 >= height_p) && (col_p + 1 >= width_p);
		smoothed_q.push_back('{smoothed: pix_t'(sum / cnt), frame_last: last});

		if (last) begin
			restart_frame();
		end else begin
			col_p++;
			if (col_p >= width_p) begin
				col_p = 0;
				row_p++;
			end
		end
	endfunction

	// Pixel values biased towards the extremes
	function automatic pix_t pick_pixel();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel == 0)
			return 8'h00;
		if (sel == 1)
			return 8'hFF;
		return pix_t'($urandom);
	endfunction

	function automatic void push_item(input logic cmd, input pix_t px);
		raster_q.push_back('{cmd: cmd, pixel: px});
	endfunction

	// One full frame plus its drains; optional noise that the block drops
	task automatic queue_frame(input int w, input int h, input bit noisy);
		int i;
		for (i = 0; i < w * h; i++) begin
			// drain ahead of the last pixel
			if (noisy && $urandom_range(99) < 4)
				push_item(CMD_DRAIN, pick_pixel());
			push_item(CMD_PIXEL, pick_pixel());
		end
		for (i = 0; i <= w; i++) begin
			// pixel while the frame is draining
			if (noisy && $urandom_range(99) < 4)
				push_item(CMD_PIXEL, pick_pixel());
			push_item(CMD_DRAIN, pick_pixel());
		end
		// surplus drain after the frame has closed
		if (noisy && $urandom_range(99) < 10)
			push_item(CMD_DRAIN, pick_pixel());
		useful_items += w * h + w + 1;
	endtask

	// APB write: setup cycle, access cycle, register taken at the end of access
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		set_frame_size(idx, val);
	endtask

	// Wait for all items and results, then let the pipeline empty
	task automatic settle();
		while (raster_q.size() != 0 || smoothed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Input driver: presents the head of the item queue, holds it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				smooth_step(raster_q.pop_front());
			if (!s_tvalid || s_tready) begin
				if (raster_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
					s_tvalid <= 1'b1;
					s_tdata <= raster_q[0].pixel;
					s_tuser <= raster_q[0].cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls plus one long hold to back the block up
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_seen >= HOLD_AFTER) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 8);
		end
	end

	// Output monitor: each transaction against the oldest expectation
	smooth_result_t head_exp;
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (smoothed_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual smoothed=%0d last=%0b",
					$time, m_tdata, m_tlast);
				errors++;
			end else begin
				head_exp = smoothed_q.pop_front();
				if (m_tdata !== head_exp.smoothed) begin
					$display("%0t: smoothed mismatch: expected %0d, actual %0d",
						$time, head_exp.smoothed, m_tdata);
					errors++;
				end
				if (m_tlast !== head_exp.frame_last) begin
					$display("%0t: frame_last mismatch: expected %0b, actual %0b",
						$time, head_exp.frame_last, m_tlast);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Phases: config, frames, settle
	initial begin
		int i, w, h, sel, nframes, cut;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// widest frame first: width above range clamps to 256, fills both line stores
		write_reg(REG_FRAME_WIDTH, 32'd300);
		write_reg(REG_FRAME_HEIGHT, 32'd2);
		queue_frame(MAX_WIDTH, 2, 1'b0);
		settle();

		// 1x1 frame from zero writes; early drain, pixel while draining, surplus drain
		write_reg(REG_FRAME_WIDTH, 32'd0);
		write_reg(REG_FRAME_HEIGHT, 32'd0);
		push_item(CMD_DRAIN, 8'hA5);
		push_item(CMD_PIXEL, 8'hFF);
		push_item(CMD_PIXEL, 8'h00);
		push_item(CMD_DRAIN, 8'hFF);
		push_item(CMD_DRAIN, 8'h5A);
		push_item(CMD_DRAIN, 8'h00);
		settle();

		// 3x3 frame, upper write bits set: corners, edges and centre
		write_reg(REG_FRAME_WIDTH, 32'hFFFF_FE03);
		write_reg(REG_FRAME_HEIGHT, 32'hFFFF_E003);
		push_item(CMD_PIXEL, 8'hFF);
		push_item(CMD_PIXEL, 8'h00);
		push_item(CMD_PIXEL, 8'hFF);
		push_item(CMD_PIXEL, 8'h00);
		push_item(CMD_PIXEL, 8'hFF);
		push_item(CMD_PIXEL, 8'h00);
		push_item(CMD_PIXEL, 8'hAA);
		push_item(CMD_PIXEL, 8'h55);
		push_item(CMD_PIXEL, 8'hFE);
		for (i = 0; i < 4; i++)
			push_item(CMD_DRAIN, 8'hFF);
		settle();

		// single-row frame: divide by two
		write_reg(REG_FRAME_WIDTH, 32'd2);
		write_reg(REG_FRAME_HEIGHT, 32'd1);
		push_item(CMD_PIXEL, 8'h01);
		push_item(CMD_PIXEL, 8'h80);
		for (i = 0; i < 3; i++)
			push_item(CMD_DRAIN, 8'h00);
		settle();

		// height above range clamps to 4096; part of a frame, then abandoned
		write_reg(REG_FRAME_HEIGHT, 32'h1FFF);
		for (i = 0; i < 40; i++)
			push_item(CMD_PIXEL, pick_pixel());
		settle();

		// random frames, mostly small, some abandoned part way
		while (useful_items < ITEM_BUDGET) begin
			sel = $urandom_range(99);
			if (sel < 80) begin
				w = $urandom_range(1, 8);
				h = $urandom_range(1, 6);
			end else if (sel < 95) begin
				w = $urandom_range(9, 40);
				h = $urandom_range(1, 8);
			end else begin
				w = $urandom_range(41, 128);
				h = $urandom_range(1, 3);
			end
			write_reg(REG_FRAME_WIDTH, w);
			write_reg(REG_FRAME_HEIGHT, h);
			nframes = $urandom_range(1, 3);
			// keep the run close to its item budget
			while (nframes > 1 && useful_items + nframes * (w * h + w + 1) > ITEM_BUDGET)
				nframes--;
			repeat (nframes) queue_frame(w, h, 1'b1);
			if (w * h > 1 && $urandom_range(9) == 0) begin
				cut = $urandom_range(1, w * h - 1);
				for (i = 0; i < cut; i++)
					push_item(CMD_PIXEL, pick_pixel());
				useful_items += cut;
			end
			settle();
		end

		// final drain of expectations and a short tail
		while (raster_q.size() != 0 || smoothed_q.size() != 0)
			@(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ibs_pkg.sv
rtl/ibs_cell.sv
rtl/ibs_line.sv
rtl/ibs_mean.sv
rtl/image_box_smoother_3x3.sv
dv/tb_top.sv
